// ===== sv/sa_lru_pkg.sv =====
// Shared constants, types and request record for the set-associative LRU tag store.
package sa_lru_pkg;

  // Cache geometry (SETS, WAYS and LINE_BYTES are powers of two)
  localparam int SETS       = 64;
  localparam int WAYS       = 4;
  localparam int LINE_BYTES = 32;

  // Fixed field widths of the channels
  localparam int ADDR_W      = 64;
  localparam int HIT_WAY_W   = 2;
  localparam int OUT_WAY_W   = 2;

  // Derived widths
  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(SETS);
  localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int RANK_W = WAY_W;
  localparam int SLOT_W = IDX_W + WAY_W;

  // Request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [WAYS-1:0][RANK_W-1:0] rank_row_t;

  // One classified access
  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [TAG_W-1:0]  tag;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic [ADDR_W-1:0] line_addr;
  } req_t;

endpackage

// ===== sv/sa_lru_ifs.sv =====
// Valid/ready channel interfaces for access items and result items.
interface sa_lru_in_if;
  import sa_lru_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    address;
  logic                 hit;
  logic [HIT_WAY_W-1:0] hit_way;

  modport source (output valid, address, hit, hit_way, input ready);
  modport sink   (input valid, address, hit, hit_way, output ready);
endinterface

interface sa_lru_out_if;
  import sa_lru_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUT_WAY_W-1:0] way;
  logic                 refill_needed;
  logic                 replaced;
  logic [ADDR_W-1:0]    refill_address;

  modport source (output valid, way, refill_needed, replaced, refill_address, input ready);
  modport sink   (input valid, way, refill_needed, replaced, refill_address, output ready);
endinterface

// ===== sv/sa_lru_front.sv =====
// Front end: accept access items and split the address into index, tag and line address.
module sa_lru_front import sa_lru_pkg::*; (
  sa_lru_in_if.sink in_ch,
  input  logic      q_full,
  output logic      q_push,
  output req_t      q_item
);

  // Take an item whenever the queue has room
  assign in_ch.ready = ~q_full;
  assign q_push      = in_ch.valid & ~q_full;

  // Classify the access
  always_comb begin
    q_item.index     = in_ch.address[OFF_W +: IDX_W];
    q_item.tag       = in_ch.address[ADDR_W-1 -: TAG_W];
    q_item.hit       = in_ch.hit;
    // reduce the hit way modulo WAYS (power of two: keep the low bits)
    q_item.hit_way   = WAY_W'(in_ch.hit_way);
    q_item.line_addr = {in_ch.address[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
  end

endmodule

// ===== sv/sa_lru_queue.sv =====
// Two-entry request queue between the front end and the update engine.
module sa_lru_queue import sa_lru_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_item,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output req_t head
);

  req_t                entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  cnt_r;
  logic [Q_CNT_W-1:0]  cnt_nxt;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = entry_r[rd_ptr_r];

  // Track occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/sa_lru_back.sv =====
// Back end: read a set's ranks, pick the way, write ranks, valid bits and tag, emit the result.
module sa_lru_back import sa_lru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  req_t        q_head,
  output logic        q_pop,
  sa_lru_out_if.source out_ch
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  req_t req_r;

  // Per-set storage
  rank_row_t        rank_mem [SETS];
  logic [TAG_W-1:0] tag_mem [SETS*WAYS];
  logic [WAYS-1:0]  valid_r [SETS];
  rank_row_t        rank_rd_r;

  // Result register
  logic                 out_valid_r;
  logic [OUT_WAY_W-1:0] out_way_r;
  logic                 out_refill_r;
  logic                 out_replaced_r;
  logic [ADDR_W-1:0]    out_addr_r;

  logic             fire;
  logic [WAYS-1:0]  vrow;
  rank_row_t        reff;
  rank_row_t        rnew;
  logic             full;
  logic [WAY_W-1:0] first_inv;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] sel;
  logic [RANK_W-1:0] old_rank;

  assign q_pop = (state_r == ST_LOAD) && q_not_empty;
  assign fire  = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  // Pick the way and compute the promoted rank row
  always_comb begin
    vrow = valid_r[req_r.index];
    for (int j = 0; j < WAYS; j++) begin
      // a way that is not valid counts as rank zero
      reff[j] = vrow[j] ? rank_rd_r[j] : '0;
    end
    full = &vrow;
    first_inv = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (!vrow[j]) begin
        first_inv = WAY_W'(j);
      end
    end
    // ties keep the current candidate, which starts as the highest way
    victim = WAY_W'(WAYS - 1);
    for (int j = 0; j < WAYS; j++) begin
      if (reff[j] < reff[victim]) begin
        victim = WAY_W'(j);
      end
    end
    if (req_r.hit) begin
      sel = req_r.hit_way;
    end else if (full) begin
      sel = victim;
    end else begin
      sel = first_inv;
    end
    old_rank = reff[sel];
    for (int j = 0; j < WAYS; j++) begin
      if (WAY_W'(j) == sel) begin
        rnew[j] = RANK_W'(WAYS - 1);
      end else if (vrow[j] && (reff[j] > old_rank)) begin
        rnew[j] = reff[j] - RANK_W'(1);
      end else begin
        rnew[j] = reff[j];
      end
    end
  end

  // Sequence: load one request, then execute it
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (q_not_empty) state_nxt = ST_EXEC;
      ST_EXEC: if (fire) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Clear valid bits at reset, set them on a fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else if (fire && !req_r.hit) begin
      valid_r[req_r.index][sel] <= 1'b1;
    end
  end

  // Memories, request hold and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r     <= q_head;
      rank_rd_r <= rank_mem[q_head.index];
    end
    if (fire) begin
      rank_mem[req_r.index] <= rnew;
      out_way_r             <= OUT_WAY_W'(sel);
      out_refill_r          <= ~req_r.hit;
      out_replaced_r        <= ~req_r.hit & full;
      out_addr_r            <= req_r.hit ? '0 : req_r.line_addr;
      if (!req_r.hit) begin
        tag_mem[{req_r.index, sel}] <= req_r.tag;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.way            = out_way_r;
  assign out_ch.refill_needed  = out_refill_r;
  assign out_ch.replaced       = out_replaced_r;
  assign out_ch.refill_address = out_addr_r;

endmodule

// ===== sv/set_assoc_lru_tag_store_core.sv =====
// Top level of the set-associative true-LRU tag store.
//
// Usage:
//   in_ch  carries one access per item: byte address, hit flag and hit way.
//   out_ch carries one result per access: touched way, refill flag,
//          replaced flag and line-aligned refill address (zero on a hit).
// An accepted access passes through a queue entry, the request register of
//   the update engine and the result register.
// The update engine loads, then executes, one access at a time; each access
//   reads one set's rank row from the rank memory, writes it back on execute.
// A two-entry queue sits between the front end and the update engine, so
//   up to three further accesses are taken while a result waits: one held
//   in the update engine and two in the queue.
// Reset (synchronous, active low) clears all valid bits, the queue and the
//   result valid flag at once; the block takes items the cycle after.
// When out_ch.ready is low the result holds, the update engine stalls,
//   the queue fills and in_ch.ready drops.
module set_assoc_lru_tag_store_core import sa_lru_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  sa_lru_in_if.sink     in_ch,
  sa_lru_out_if.source  out_ch
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  req_t q_item;
  req_t q_head;

  sa_lru_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_item)
  );

  sa_lru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  sa_lru_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

// ===== sv/sa_lru_checker.sv =====
// Port-level checks for the LRU tag store, bound to the top level.
module sa_lru_checker import sa_lru_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_WAY_W-1:0] out_way,
  input logic                 out_refill_needed,
  input logic                 out_replaced,
  input logic [ADDR_W-1:0]    out_refill_address
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_way) &&
      $stable(out_refill_needed) && $stable(out_replaced) && $stable(out_refill_address))
    else $error("stalled result changed");

  // A hit reports no eviction and a zero refill address
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_refill_needed |-> !out_replaced && (out_refill_address == '0))
    else $error("hit result carries refill data");

  // Refill address is line aligned
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_refill_address[OFF_W-1:0] == '0))
    else $error("refill address not line aligned");

endmodule

bind set_assoc_lru_tag_store_core sa_lru_checker u_sa_lru_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_way            (out_ch.way),
  .out_refill_needed  (out_ch.refill_needed),
  .out_replaced       (out_ch.replaced),
  .out_refill_address (out_ch.refill_address)
);
